/* hdl/ccml_pkg.sv */
// ----------------------------------------------------------------------------
// ccml_pkg
// Shared types and constants for the character class map lookup block.
// ----------------------------------------------------------------------------
package ccml_pkg;

   localparam int CP_BITS     = 21;
   localparam int VALUE_BITS  = 16;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;

   localparam int RANGE_ENTRIES_DEFAULT = 64;
   localparam int DIRECT_SIZE_DEFAULT   = 128;

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOAD   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

   // load status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_REVERSED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIRECT,
      ST_SWEEP,
      ST_SEARCH
   } ccml_state_type;

   // source of the result fields
   typedef enum logic [2:0] {
      RES_ZERO,
      RES_STATUS,
      RES_DIRECT,
      RES_DEFAULT,
      RES_RANGE
   } ccml_res_sel_type;

   typedef struct packed {
      logic [CP_BITS-1:0]    range_start;
      logic [CP_BITS-1:0]    range_end;
      logic [VALUE_BITS-1:0] value;
   } ccml_row_type;

   // controller to datapath
   typedef struct packed {
      logic             capture;
      logic             decode_load;
      logic             clear;
      logic             direct_read;
      logic             sweep_write;
      logic             search_init;
      logic             search_step;
      logic             emit;
      ccml_res_sel_type res_sel;
   } ccml_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 cp_low;
      logic                 lookup_skip;
      logic                 load_direct;
      logic                 sweep_last;
      logic                 search_hit;
      logic                 search_more;
   } ccml_stat_type;

endpackage

/* hdl/character_class_map_lookup.sv */
// ----------------------------------------------------------------------------
// character_class_map_lookup
// Maps a code point to a binding value through a direct map for low code
// points and a binary-searched interval table for the rest.
// ----------------------------------------------------------------------------
// Sequence: clear, unused kinds, reversed loads and lookups outside the table
//   bounds emit from decode; direct map lookups read the map, then emit; range
//   lookups run search probes (at most log2(entries) + 1, one per cycle through
//   the range table read port); loads write their direct entries, one per cycle
//   through the direct map write port. The result strobe is registered from emit.
// Throughput: one item at a time; the next item is taken in the strobe cycle.
// Reset: synchronous; no clearing pass. The receiver cannot stall.
module character_class_map_lookup #(
   parameter int RANGE_ENTRIES = ccml_pkg::RANGE_ENTRIES_DEFAULT,
   parameter int DIRECT_SIZE   = ccml_pkg::DIRECT_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // item channel
   input  logic                             start,
   output logic                             busy,
   input  logic [ccml_pkg::KIND_BITS-1:0]   req_kind,
   input  logic [ccml_pkg::CP_BITS-1:0]     req_code_point,
   input  logic [ccml_pkg::CP_BITS-1:0]     req_range_first,
   input  logic [ccml_pkg::CP_BITS-1:0]     req_range_last,
   input  logic [ccml_pkg::VALUE_BITS-1:0]  req_bound_value,
   // result channel
   output logic                             rsp_valid,
   output logic [ccml_pkg::VALUE_BITS-1:0]  rsp_mapped_value,
   output logic                             rsp_matched,
   output logic [ccml_pkg::STATUS_BITS-1:0] rsp_status,
   // default value register
   input  logic                             csr_write_enable,
   input  logic [ccml_pkg::VALUE_BITS-1:0]  csr_write_data
);
   import ccml_pkg::*;

   // Command and status between sequencer and datapath.
   ccml_cmd_type  cmd;
   ccml_stat_type stat;

   // Sequencer: decode each item, then drive the direct read, the fill sweep
   // of the direct map, or the binary search, and emit one result per item.
   ccml_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Datapath: holds the item, the direct map (set bits in flops, values in
   // memory; an unset entry reads as the value latched at the last clear),
   // the range table memory with its fill count, and the result register.
   ccml_datapath #(
      .RANGE_ENTRIES (RANGE_ENTRIES),
      .DIRECT_SIZE   (DIRECT_SIZE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_code_point   (req_code_point),
      .req_range_first  (req_range_first),
      .req_range_last   (req_range_last),
      .req_bound_value  (req_bound_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_matched      (rsp_matched),
      .rsp_status       (rsp_status)
   );

endmodule

/* hdl/ccml_controller.sv */
// ----------------------------------------------------------------------------
// ccml_controller
// Sequencer: decodes each item and steps the datapath through direct reads,
// direct map fill sweeps and the range table search.
// ----------------------------------------------------------------------------
module ccml_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ccml_pkg::ccml_stat_type stat,
   output ccml_pkg::ccml_cmd_type  cmd
);
   import ccml_pkg::*;

   ccml_state_type state_ff;
   ccml_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (stat.kind == KIND_LOOKUP) begin
               if (stat.cp_low) begin
                  state_in = ST_DIRECT;
               end else if (!stat.lookup_skip) begin
                  state_in = ST_SEARCH;
               end
            end else if (stat.kind == KIND_LOAD) begin
               if (stat.load_direct) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_DIRECT: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (stat.search_hit || !stat.search_more) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.res_sel = RES_ZERO;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_DECODE: begin
            if (stat.kind == KIND_LOOKUP) begin
               if (stat.cp_low) begin
                  cmd.direct_read = 1'b1;
               end else if (stat.lookup_skip) begin
                  cmd.emit    = 1'b1;
                  cmd.res_sel = RES_DEFAULT;
               end else begin
                  cmd.search_init = 1'b1;
               end
            end else if (stat.kind == KIND_LOAD) begin
               cmd.decode_load = 1'b1;
               if (!stat.load_direct) begin
                  cmd.emit    = 1'b1;
                  cmd.res_sel = RES_STATUS;
               end
            end else if (stat.kind == KIND_CLEAR) begin
               cmd.clear = 1'b1;
               cmd.emit  = 1'b1;
            end else begin
               cmd.emit = 1'b1;
            end
         end
         ST_DIRECT: begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_DIRECT;
         end
         ST_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_STATUS;
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (stat.search_hit) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_RANGE;
            end else if (!stat.search_more) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_DEFAULT;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !busy)
      else $error("block still busy after emitting a result");

   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit)
      else $error("two results emitted back to back for one item");

endmodule

/* hdl/ccml_datapath.sv */
// ----------------------------------------------------------------------------
// ccml_datapath
// Item registers, direct map memory with set bits, range table memory,
// binary search registers and the result register.
// ----------------------------------------------------------------------------
module ccml_datapath #(
   parameter int RANGE_ENTRIES = ccml_pkg::RANGE_ENTRIES_DEFAULT,
   parameter int DIRECT_SIZE   = ccml_pkg::DIRECT_SIZE_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ccml_pkg::KIND_BITS-1:0]        req_kind,
   input  logic [ccml_pkg::CP_BITS-1:0]          req_code_point,
   input  logic [ccml_pkg::CP_BITS-1:0]          req_range_first,
   input  logic [ccml_pkg::CP_BITS-1:0]          req_range_last,
   input  logic [ccml_pkg::VALUE_BITS-1:0]       req_bound_value,
   input  logic                                  csr_write_enable,
   input  logic [ccml_pkg::VALUE_BITS-1:0]       csr_write_data,
   input  ccml_pkg::ccml_cmd_type                cmd,
   output ccml_pkg::ccml_stat_type               stat,
   output logic                                  rsp_valid,
   output logic [ccml_pkg::VALUE_BITS-1:0]       rsp_mapped_value,
   output logic                                  rsp_matched,
   output logic [ccml_pkg::STATUS_BITS-1:0]      rsp_status
);
   import ccml_pkg::*;

   localparam int IW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
   localparam int CW = $clog2(RANGE_ENTRIES + 1);
   localparam int DW = (DIRECT_SIZE > 1) ? $clog2(DIRECT_SIZE) : 1;
   localparam logic [CP_BITS-1:0] DIRECT_LIMIT = CP_BITS'(DIRECT_SIZE);

   // item registers
   logic [KIND_BITS-1:0]  kind_ff;
   logic [CP_BITS-1:0]    cp_ff;
   logic [CP_BITS-1:0]    first_ff;
   logic [CP_BITS-1:0]    last_ff;
   logic [VALUE_BITS-1:0] bval_ff;

   // configuration and table state
   logic [VALUE_BITS-1:0] default_ff;
   logic [VALUE_BITS-1:0] clear_value_ff;
   logic                  direct_set_ff [DIRECT_SIZE];
   logic [VALUE_BITS-1:0] direct_mem    [DIRECT_SIZE];
   ccml_row_type          range_mem     [RANGE_ENTRIES];
   logic [CW-1:0]         count_ff;
   logic [CP_BITS-1:0]    first_start_ff;
   logic [CP_BITS-1:0]    last_end_ff;

   // work registers
   logic [DW-1:0]          dptr_ff;
   logic [STATUS_BITS-1:0] status_ff;
   logic [VALUE_BITS-1:0]  dir_rd_ff;
   logic                   set_rd_ff;
   logic [CW-1:0]          lo_ff;
   logic [CW-1:0]          hip1_ff;
   logic [IW-1:0]          mid_ff;
   ccml_row_type           row_ff;

   // result registers
   logic                   rsp_valid_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;
   logic                   rsp_matched_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [VALUE_BITS-1:0]  rsp_value_in;
   logic                   rsp_matched_in;
   logic [STATUS_BITS-1:0] rsp_status_in;

   // decode of the captured item
   logic                  reversed;
   logic                  has_upper;
   logic                  table_full;
   logic                  do_append;
   logic [STATUS_BITS-1:0] status_in;
   logic [DW-1:0]         direct_last;
   logic [CP_BITS-1:0]    append_start;
   logic                  above_end;
   logic                  below_start;
   logic [CW-1:0]         lo_in;
   logic [CW-1:0]         hip1_in;
   logic [CW:0]           mid_sum;
   logic [IW-1:0]         mid_in;
   logic                  search_load;

   assign reversed     = (first_ff > last_ff);
   assign has_upper    = (last_ff >= DIRECT_LIMIT);
   assign table_full   = (count_ff >= CW'(RANGE_ENTRIES));
   assign do_append    = !reversed && has_upper && !table_full;
   assign direct_last  = has_upper ? DW'(DIRECT_SIZE - 1) : last_ff[DW-1:0];
   assign append_start = (first_ff < DIRECT_LIMIT) ? DIRECT_LIMIT : first_ff;

   // load status, valid while the load is being decoded
   always_comb begin
      if (reversed) begin
         status_in = STATUS_REVERSED;
      end else if (has_upper && table_full) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // binary search step: end compare first, then start compare
   assign above_end   = (cp_ff > row_ff.range_end);
   assign below_start = (cp_ff < row_ff.range_start);

   always_comb begin
      lo_in   = lo_ff;
      hip1_in = hip1_ff;
      if (cmd.search_init) begin
         lo_in   = '0;
         hip1_in = count_ff;
      end else if (above_end) begin
         lo_in = CW'(mid_ff) + CW'(1);
      end else if (below_start) begin
         hip1_in = CW'(mid_ff);
      end
   end

   assign mid_sum     = {1'b0, lo_in} + {1'b0, hip1_in} - (CW + 1)'(1);
   assign mid_in      = mid_sum[IW:1];
   assign search_load = cmd.search_init || (cmd.search_step && (hip1_in > lo_in));

   assign stat.kind        = kind_ff;
   assign stat.cp_low      = (cp_ff < DIRECT_LIMIT);
   assign stat.lookup_skip = (count_ff == '0) || (cp_ff < first_start_ff)
                             || (cp_ff > last_end_ff);
   assign stat.load_direct = !reversed && (first_ff < DIRECT_LIMIT);
   assign stat.sweep_last  = (dptr_ff == direct_last);
   assign stat.search_hit  = !above_end && !below_start;
   assign stat.search_more = (hip1_in > lo_in);

   // capture item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         cp_ff    <= req_code_point;
         first_ff <= req_range_first;
         last_ff  <= req_range_last;
         bval_ff  <= req_bound_value;
      end
   end

   // configuration and clear value
   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff     <= '0;
         clear_value_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            default_ff <= csr_write_data;
         end
         if (cmd.clear) begin
            clear_value_ff <= default_ff;
         end
      end
   end

   // set bits: reset and clear drop them all at once
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < DIRECT_SIZE; i++) begin
            direct_set_ff[i] <= 1'b0;
         end
      end else if (cmd.sweep_write) begin
         direct_set_ff[dptr_ff] <= 1'b1;
      end
   end

   // direct map memory
   always_ff @(posedge clock) begin
      if (cmd.sweep_write) begin
         direct_mem[dptr_ff] <= bval_ff;
      end
      if (cmd.direct_read) begin
         dir_rd_ff <= direct_mem[cp_ff[DW-1:0]];
         set_rd_ff <= direct_set_ff[cp_ff[DW-1:0]];
      end
   end

   // sweep pointer and load status
   always_ff @(posedge clock) begin
      if (cmd.decode_load) begin
         dptr_ff   <= first_ff[DW-1:0];
         status_ff <= status_in;
      end else if (cmd.sweep_write) begin
         dptr_ff <= dptr_ff + DW'(1);
      end
   end

   // range table fill count and bounds
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.decode_load && do_append) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode_load && do_append) begin
         last_end_ff <= last_ff;
         if (count_ff == '0) begin
            first_start_ff <= append_start;
         end
      end
   end

   // range table memory
   always_ff @(posedge clock) begin
      if (cmd.decode_load && do_append) begin
         range_mem[count_ff[IW-1:0]] <= '{range_start: append_start,
                                         range_end:   last_ff,
                                         value:       bval_ff};
      end
      if (search_load) begin
         row_ff <= range_mem[mid_in];
      end
   end

   // search bounds
   always_ff @(posedge clock) begin
      if (search_load) begin
         lo_ff   <= lo_in;
         hip1_ff <= hip1_in;
         mid_ff  <= mid_in;
      end
   end

   // result register: one strobe per emit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   // a load that emits while it is decoded takes its status straight from decode
   always_comb begin
      rsp_value_in   = '0;
      rsp_matched_in = 1'b0;
      rsp_status_in  = STATUS_OK;
      case (cmd.res_sel)
         RES_STATUS: begin
            rsp_status_in = cmd.decode_load ? status_in : status_ff;
         end
         RES_DIRECT: begin
            rsp_value_in   = set_rd_ff ? dir_rd_ff : clear_value_ff;
            rsp_matched_in = set_rd_ff;
         end
         RES_DEFAULT: begin
            rsp_value_in = default_ff;
         end
         RES_RANGE: begin
            rsp_value_in   = row_ff.value;
            rsp_matched_in = 1'b1;
         end
         default: begin
            rsp_value_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff   <= rsp_value_in;
         rsp_matched_ff <= rsp_matched_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_value = rsp_value_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_status       = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RANGE_ENTRIES))
      else $error("range table count beyond capacity");

   a_mid_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.search_step |-> (CW'(mid_ff) < count_ff))
      else $error("search probe outside the filled range table");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_write |-> (dptr_ff <= direct_last))
      else $error("fill sweep ran past the end of the interval");

endmodule
